FILE: sv/hpi_pkg.sv
// Shared types and constants of the height profile interpolator.
`default_nettype none

package hpi_pkg;

    // Default table geometry
    localparam int LEVELS_DEF   = 16;
    localparam int PROFILES_DEF = 64;

    // Field widths
    localparam int HGT_W = 16;
    localparam int VAL_W = 32;
    localparam int ENT_W = HGT_W + 3 * VAL_W;
    localparam int DIF_W = VAL_W + 1;
    localparam int NUM_W = HGT_W + 1;
    localparam int PRD_W = DIF_W + NUM_W;
    localparam int MAG_W = 48;
    localparam int DVS_W = 16;
    localparam int STP_W = 6;

    // Entry layout in the table memory: height, transmission, upwelled, downwelled
    localparam int HGT_LSB = 3 * VAL_W;
    localparam int TRN_LSB = 2 * VAL_W;
    localparam int UPW_LSB = VAL_W;
    localparam int DNW_LSB = 0;

    // Operation codes
    localparam logic OPC_LOAD  = 1'b0;
    localparam logic OPC_QUERY = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_RD_B,
        ST_RD_A,
        ST_LERP_LD,
        ST_LERP_RUN,
        ST_DONE
    } t_state;

    // Interpolation lane states
    typedef enum logic [2:0] {
        LS_IDLE,
        LS_MUL,
        LS_PREP,
        LS_DIV,
        LS_DONE
    } t_lerp_state;

    // Start and shared operands handed to each interpolation lane
    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic signed [NUM_W-1:0] den;
    } t_lerp_req;

endpackage

`default_nettype wire

FILE: sv/hpi_if.sv
// Input and output channel interfaces of the height profile interpolator.
`default_nettype none

interface hpi_in_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [5:0]                          profile;
    logic [3:0]                          level;
    logic signed [hpi_pkg::HGT_W-1:0]    level_height;
    logic signed [hpi_pkg::VAL_W-1:0]    level_transmission;
    logic signed [hpi_pkg::VAL_W-1:0]    level_upwelled;
    logic signed [hpi_pkg::VAL_W-1:0]    level_downwelled;
    logic signed [hpi_pkg::HGT_W-1:0]    query_height;

    modport source (
        output valid, opcode, profile, level, level_height, level_transmission,
               level_upwelled, level_downwelled, query_height,
        input  ready
    );
    modport sink (
        input  valid, opcode, profile, level, level_height, level_transmission,
               level_upwelled, level_downwelled, query_height,
        output ready
    );
endinterface

interface hpi_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [hpi_pkg::VAL_W-1:0]    transmission;
    logic signed [hpi_pkg::VAL_W-1:0]    upwelled;
    logic signed [hpi_pkg::VAL_W-1:0]    downwelled;
    logic                                clamped;

    modport source (
        output valid, transmission, upwelled, downwelled, clamped,
        input  ready
    );
    modport sink (
        input  valid, transmission, upwelled, downwelled, clamped,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/hpi_ram.sv
// Generic single-port-write, registered-read synchronous RAM.
`default_nettype none

module hpi_ram #(
    parameter int WIDTH = hpi_pkg::ENT_W,
    parameter int DEPTH = hpi_pkg::LEVELS_DEF * hpi_pkg::PROFILES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry through the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/hpi_lerp.sv
// One interpolation lane: b + trunc((a - b) * num / den) with a bit-serial divide.
`default_nettype none

module hpi_lerp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire hpi_pkg::t_lerp_req                  i_req,
    input  wire logic signed [hpi_pkg::VAL_W-1:0]    i_b,
    input  wire logic signed [hpi_pkg::VAL_W-1:0]    i_a,
    output logic                                     o_done,
    output logic signed [hpi_pkg::VAL_W-1:0]         o_res
);

    hpi_pkg::t_lerp_state r_state, n_state;

    logic signed [hpi_pkg::VAL_W-1:0] r_b;
    logic signed [hpi_pkg::DIF_W-1:0] r_diff;
    logic signed [hpi_pkg::NUM_W-1:0] r_num;
    logic signed [hpi_pkg::NUM_W-1:0] r_den;
    logic signed [hpi_pkg::PRD_W-1:0] r_prod;
    logic [hpi_pkg::MAG_W-1:0]        r_quo;
    logic [hpi_pkg::DVS_W-1:0]        r_rem;
    logic [hpi_pkg::DVS_W-1:0]        r_dvs;
    logic                             r_neg;
    logic [hpi_pkg::STP_W-1:0]        r_step;

    logic                             l_take;
    logic                             l_last;
    logic signed [hpi_pkg::PRD_W-1:0] l_prod_neg;
    logic signed [hpi_pkg::NUM_W-1:0] l_den_neg;
    logic [hpi_pkg::DVS_W:0]          l_shift;
    logic [hpi_pkg::DVS_W:0]          l_sub;
    logic                             l_qbit;
    logic [hpi_pkg::VAL_W-1:0]        l_q;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hpi_pkg::LS_IDLE, hpi_pkg::LS_DONE: begin
                if (i_req.start) begin
                    n_state = hpi_pkg::LS_MUL;
                end
            end
            hpi_pkg::LS_MUL:  n_state = hpi_pkg::LS_PREP;
            hpi_pkg::LS_PREP: n_state = hpi_pkg::LS_DIV;
            hpi_pkg::LS_DIV: begin
                if (l_last) begin
                    n_state = hpi_pkg::LS_DONE;
                end
            end
            default: n_state = hpi_pkg::LS_IDLE;
        endcase
    end

    // Outputs and control
    always_comb begin
        l_take = i_req.start &&
                 (r_state == hpi_pkg::LS_IDLE || r_state == hpi_pkg::LS_DONE);
        l_last = (r_step == hpi_pkg::STP_W'(hpi_pkg::MAG_W - 1));
        o_done = (r_state == hpi_pkg::LS_DONE);
    end

    // Magnitudes and one restoring divide step
    always_comb begin
        l_prod_neg = -r_prod;
        l_den_neg  = -r_den;
        l_shift    = {r_rem, r_quo[hpi_pkg::MAG_W-1]};
        l_sub      = l_shift - {1'b0, r_dvs};
        l_qbit     = (l_shift >= {1'b0, r_dvs});
    end

    // Apply sign, add back to the lower value; a zero span returns the lower value
    always_comb begin
        l_q   = r_neg ? (hpi_pkg::VAL_W'(0) - r_quo[hpi_pkg::VAL_W-1:0])
                      : r_quo[hpi_pkg::VAL_W-1:0];
        o_res = (r_den == '0) ? r_b : (r_b + $signed(l_q));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hpi_pkg::LS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (l_take) begin
            r_b    <= i_b;
            r_diff <= {i_a[hpi_pkg::VAL_W-1], i_a} - {i_b[hpi_pkg::VAL_W-1], i_b};
            r_num  <= i_req.num;
            r_den  <= i_req.den;
        end
        case (r_state)
            hpi_pkg::LS_MUL: begin
                r_prod <= r_diff * r_num;
            end
            hpi_pkg::LS_PREP: begin
                r_quo  <= r_prod[hpi_pkg::PRD_W-1] ? l_prod_neg[hpi_pkg::MAG_W-1:0]
                                                   : r_prod[hpi_pkg::MAG_W-1:0];
                r_dvs  <= r_den[hpi_pkg::NUM_W-1] ? l_den_neg[hpi_pkg::DVS_W-1:0]
                                                  : r_den[hpi_pkg::DVS_W-1:0];
                r_rem  <= '0;
                r_neg  <= r_prod[hpi_pkg::PRD_W-1] ^ r_den[hpi_pkg::NUM_W-1];
                r_step <= '0;
            end
            hpi_pkg::LS_DIV: begin
                r_quo  <= {r_quo[hpi_pkg::MAG_W-2:0], l_qbit};
                r_rem  <= l_qbit ? l_sub[hpi_pkg::DVS_W-1:0] : l_shift[hpi_pkg::DVS_W-1:0];
                r_step <= r_step + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/height_profile_interpolator_top.sv
// Top level of the height profile interpolator: level table memory, search sequencer, lanes.
// Load: written to the table on acceptance. Query outside the profile range: result with no scan.
// Clamped query: result after a scan of all LEVELS heights (one height read per cycle).
// Interpolated query: the scan is followed by the 48-step divide in each lane.
// Synchronous active-low reset clears control only; table entries are undefined until loaded.
`default_nettype none

module height_profile_interpolator_top #(
    parameter int LEVELS   = hpi_pkg::LEVELS_DEF,
    parameter int PROFILES = hpi_pkg::PROFILES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hpi_in_if.sink     i_in,
    hpi_out_if.source  o_out
);

    localparam int DEPTH = PROFILES * LEVELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(LEVELS);

    hpi_pkg::t_state r_state, n_state;

    logic                              r_rd_vld;
    logic [LW-1:0]                     r_cnt;
    logic [LW-1:0]                     r_below;
    logic [AW-1:0]                     r_base;
    logic signed [hpi_pkg::HGT_W-1:0]  r_q;
    logic signed [hpi_pkg::HGT_W-1:0]  r_hb;
    logic signed [hpi_pkg::VAL_W-1:0]  r_res_trn;
    logic signed [hpi_pkg::VAL_W-1:0]  r_res_upw;
    logic signed [hpi_pkg::VAL_W-1:0]  r_res_dnw;
    logic                              r_res_clamp;
    logic                              r_out_vld;
    logic signed [hpi_pkg::VAL_W-1:0]  r_out_trn;
    logic signed [hpi_pkg::VAL_W-1:0]  r_out_upw;
    logic signed [hpi_pkg::VAL_W-1:0]  r_out_dnw;
    logic                              r_out_clamp;

    logic                              l_acc;
    logic                              l_prof_ok;
    logic                              l_lev_ok;
    logic                              l_we;
    logic [AW-1:0]                     l_waddr;
    logic [hpi_pkg::ENT_W-1:0]         l_wdata;
    logic [AW-1:0]                     l_raddr;
    logic [hpi_pkg::ENT_W-1:0]         l_rdata;
    logic signed [hpi_pkg::HGT_W-1:0]  l_rd_h;
    logic signed [hpi_pkg::VAL_W-1:0]  l_rd_trn;
    logic signed [hpi_pkg::VAL_W-1:0]  l_rd_upw;
    logic signed [hpi_pkg::VAL_W-1:0]  l_rd_dnw;
    logic                              l_interp;
    logic                              l_out_free;
    logic                              l_lanes_done;
    hpi_pkg::t_lerp_req                l_req;
    logic [2:0]                        l_done;
    logic signed [hpi_pkg::VAL_W-1:0]  l_res_trn;
    logic signed [hpi_pkg::VAL_W-1:0]  l_res_upw;
    logic signed [hpi_pkg::VAL_W-1:0]  l_res_dnw;

    // Decode the input item and the read port
    always_comb begin
        l_acc      = i_in.valid && i_in.ready;
        l_prof_ok  = (32'(i_in.profile) < 32'(PROFILES));
        l_lev_ok   = (32'(i_in.level) < 32'(LEVELS));
        l_we       = l_acc && (i_in.opcode == hpi_pkg::OPC_LOAD) && l_prof_ok && l_lev_ok;
        l_waddr    = AW'(32'(i_in.profile) * 32'(LEVELS) + 32'(i_in.level));
        l_wdata    = {i_in.level_height, i_in.level_transmission,
                      i_in.level_upwelled, i_in.level_downwelled};
        l_rd_h     = l_rdata[hpi_pkg::HGT_LSB +: hpi_pkg::HGT_W];
        l_rd_trn   = l_rdata[hpi_pkg::TRN_LSB +: hpi_pkg::VAL_W];
        l_rd_upw   = l_rdata[hpi_pkg::UPW_LSB +: hpi_pkg::VAL_W];
        l_rd_dnw   = l_rdata[hpi_pkg::DNW_LSB +: hpi_pkg::VAL_W];
        l_interp   = (r_below != LW'(LEVELS - 1)) && !(r_q < l_rd_h);
        l_out_free = !r_out_vld || o_out.ready;
        l_lanes_done = &l_done;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hpi_pkg::ST_IDLE: begin
                if (l_acc && i_in.opcode == hpi_pkg::OPC_QUERY) begin
                    n_state = l_prof_ok ? hpi_pkg::ST_SCAN : hpi_pkg::ST_DONE;
                end
            end
            hpi_pkg::ST_SCAN: begin
                if (r_cnt == LW'(LEVELS - 1)) begin
                    n_state = hpi_pkg::ST_SCAN_END;
                end
            end
            hpi_pkg::ST_SCAN_END: n_state = hpi_pkg::ST_RD_B;
            hpi_pkg::ST_RD_B:     n_state = hpi_pkg::ST_RD_A;
            hpi_pkg::ST_RD_A: begin
                n_state = l_interp ? hpi_pkg::ST_LERP_LD : hpi_pkg::ST_DONE;
            end
            hpi_pkg::ST_LERP_LD:  n_state = hpi_pkg::ST_LERP_RUN;
            hpi_pkg::ST_LERP_RUN: begin
                if (l_lanes_done) begin
                    n_state = hpi_pkg::ST_DONE;
                end
            end
            hpi_pkg::ST_DONE: begin
                if (l_out_free) begin
                    n_state = hpi_pkg::ST_IDLE;
                end
            end
            default: n_state = hpi_pkg::ST_IDLE;
        endcase
    end

    // Outputs: ready, read address, lane start
    always_comb begin
        i_in.ready = (r_state == hpi_pkg::ST_IDLE);
        l_req.start = (r_state == hpi_pkg::ST_LERP_LD);
        l_req.num   = {r_q[hpi_pkg::HGT_W-1], r_q} - {r_hb[hpi_pkg::HGT_W-1], r_hb};
        l_req.den   = {l_rd_h[hpi_pkg::HGT_W-1], l_rd_h} - {r_hb[hpi_pkg::HGT_W-1], r_hb};
        unique case (r_state)
            hpi_pkg::ST_SCAN: l_raddr = r_base + AW'(r_cnt);
            hpi_pkg::ST_RD_A: l_raddr = r_base + AW'(r_below) + AW'(1);
            default:          l_raddr = r_base + AW'(r_below);
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hpi_pkg::ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == hpi_pkg::ST_SCAN);
            if (r_state == hpi_pkg::ST_DONE && l_out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Query datapath: scan heights, hold the lower level, collect the result
    always_ff @(posedge i_clk) begin
        case (r_state)
            hpi_pkg::ST_IDLE: begin
                r_q         <= i_in.query_height;
                r_base      <= AW'(32'(i_in.profile) * 32'(LEVELS));
                r_cnt       <= '0;
                r_below     <= '0;
                r_res_trn   <= '0;
                r_res_upw   <= '0;
                r_res_dnw   <= '0;
                r_res_clamp <= 1'b1;
            end
            hpi_pkg::ST_SCAN: begin
                r_cnt <= r_cnt + 1'b1;
            end
            hpi_pkg::ST_RD_A: begin
                r_hb        <= l_rd_h;
                r_res_trn   <= l_rd_trn;
                r_res_upw   <= l_rd_upw;
                r_res_dnw   <= l_rd_dnw;
                r_res_clamp <= !l_interp;
            end
            hpi_pkg::ST_LERP_RUN: begin
                if (l_lanes_done) begin
                    r_res_trn <= l_res_trn;
                    r_res_upw <= l_res_upw;
                    r_res_dnw <= l_res_dnw;
                end
            end
            default: begin
            end
        endcase
        // Track the last level lying strictly below the query
        if (r_rd_vld && (l_rd_h < r_q)) begin
            r_below <= r_cnt - 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (r_state == hpi_pkg::ST_DONE && l_out_free) begin
            r_out_trn   <= r_res_trn;
            r_out_upw   <= r_res_upw;
            r_out_dnw   <= r_res_dnw;
            r_out_clamp <= r_res_clamp;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.transmission = r_out_trn;
    assign o_out.upwelled     = r_out_upw;
    assign o_out.downwelled   = r_out_dnw;
    assign o_out.clamped      = r_out_clamp;

    hpi_ram #(
        .WIDTH (hpi_pkg::ENT_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    hpi_lerp u_lerp_trn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (l_req),
        .i_b     (r_res_trn),
        .i_a     (l_rd_trn),
        .o_done  (l_done[0]),
        .o_res   (l_res_trn)
    );

    hpi_lerp u_lerp_upw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (l_req),
        .i_b     (r_res_upw),
        .i_a     (l_rd_upw),
        .o_done  (l_done[1]),
        .o_res   (l_res_upw)
    );

    hpi_lerp u_lerp_dnw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (l_req),
        .i_b     (r_res_dnw),
        .i_a     (l_rd_dnw),
        .o_done  (l_done[2]),
        .o_res   (l_res_dnw)
    );

`ifndef SYNTH
    // Interpolation never starts from the last level
    a_no_interp_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hpi_pkg::ST_LERP_RUN) |-> (r_below != LW'(LEVELS - 1)))
        else $error("interpolation started from the last level");

    // The three lanes run in lockstep
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (l_done[0] == l_done[1]) && (l_done[1] == l_done[2]))
        else $error("interpolation lanes out of step");

    // A finished result lands in the output register
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hpi_pkg::ST_DONE && l_out_free) |=> r_out_vld)
        else $error("finished result not presented");

    // A new output item only comes from a finished query
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == hpi_pkg::ST_DONE))
        else $error("output item without a finished query");

    // No item is taken while the scan is running
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> !l_acc)
        else $error("item accepted during a scan");
`endif

endmodule

`default_nettype wire
